/* hdl/sit_pkg.sv */
// shared constants, payload types and controller states for the sorted id table
`timescale 1ns / 1ps

package sit_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ID_W            = 32;
	localparam int SLOT_W          = 4;
	localparam int POS_W           = 4;
	localparam int KIND_W          = 2;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   user_id;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] position;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t data;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEL,
		ST_INS,
		ST_TAIL,
		ST_FIN
	} state_t;

endpackage

/* hdl/sit_stream_if.sv */
// valid/ready stream interface carrying one payload beat
`timescale 1ns / 1ps

interface sit_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sit_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/sit_seq.sv */
// sequencer: scan, delete and insert passes over the id ram
`timescale 1ns / 1ps

module sit_seq #(
	parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	sit_stream_if.sink               req,
	input  logic                     out_free,
	output sit_pkg::res_t            res,
	output logic                     ram_we,
	output logic [IDX_W-1:0]         ram_waddr,
	output logic [sit_pkg::ID_W-1:0] ram_wdata,
	output logic [IDX_W-1:0]         ram_raddr,
	input  logic [sit_pkg::ID_W-1:0] ram_rdata
);

	localparam int POS_W = sit_pkg::POS_W;
	localparam int ID_W  = sit_pkg::ID_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(TABLE_DEPTH - 2);

	sit_pkg::state_t state_q, state_d;

	logic [ID_W-1:0]        key_q;
	logic [ID_W-1:0]        carry_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic                   rd_done_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   rv_s1;
	logic [IDX_W-1:0]       ri_s1;
	logic                   vb_s1;

	logic             accept;
	logic             in_range;
	logic             is_wc;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] rd_last;
	logic             rd_issue;
	logic             pass_end;
	logic [ID_W-1:0]  rdata_eff;
	logic             gt_carry;
	logic             gt_key;

	assign accept    = req.valid && req.ready;
	assign in_range  = 32'(req.data.slot) < 32'(TABLE_DEPTH);
	assign is_wc     = (req.data.kind == sit_pkg::KIND_WRITE) ||
		(req.data.kind == sit_pkg::KIND_CLEAR);
	assign slot_idx  = IDX_W'(req.data.slot);
	assign rd_last   = (state_q == sit_pkg::ST_INS) ? PEN_IDX : LAST_IDX;
	assign rd_issue  = !rd_done_q && ((state_q == sit_pkg::ST_SCAN) ||
		(state_q == sit_pkg::ST_DEL) || (state_q == sit_pkg::ST_INS));
	assign pass_end  = rd_done_q && !rv_s1;
	assign rdata_eff = vb_s1 ? ram_rdata : '0;
	assign gt_carry  = rdata_eff > carry_q;
	assign gt_key    = rdata_eff > key_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sit_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.data.kind == sit_pkg::KIND_LOOKUP) begin
						state_d = sit_pkg::ST_SCAN;
					end else if (is_wc && in_range) begin
						state_d = (slot_idx == LAST_IDX) ? sit_pkg::ST_INS : sit_pkg::ST_DEL;
					end else begin
						state_d = sit_pkg::ST_FIN;
					end
				end
			end
			sit_pkg::ST_SCAN: begin
				if (pass_end) begin
					state_d = sit_pkg::ST_FIN;
				end
			end
			sit_pkg::ST_DEL: begin
				if (pass_end) begin
					state_d = sit_pkg::ST_INS;
				end
			end
			sit_pkg::ST_INS: begin
				if (pass_end) begin
					state_d = sit_pkg::ST_TAIL;
				end
			end
			sit_pkg::ST_TAIL: begin
				state_d = sit_pkg::ST_FIN;
			end
			sit_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = sit_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sit_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready         = 1'b0;
		ram_we            = 1'b0;
		ram_waddr         = ri_s1;
		ram_wdata         = rdata_eff;
		ram_raddr         = rd_idx_q;
		res.valid         = 1'b0;
		res.data.hit      = hit_q;
		res.data.position = hit_q ? POS_W'(cnt_q) : '0;
		case (state_q)
			sit_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			sit_pkg::ST_DEL: begin
				// shift the entries after the slot down by one
				ram_we    = rv_s1;
				ram_waddr = ri_s1 - IDX_W'(1);
			end
			sit_pkg::ST_INS: begin
				ram_we    = rv_s1;
				ram_wdata = gt_carry ? rdata_eff : carry_q;
			end
			sit_pkg::ST_TAIL: begin
				ram_we    = 1'b1;
				ram_waddr = LAST_IDX;
				ram_wdata = carry_q;
			end
			sit_pkg::ST_FIN: begin
				res.valid = out_free;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sit_pkg::ST_IDLE;
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
			rv_s1     <= 1'b0;
			valid_q   <= '0;
			hit_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rd_issue;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q != state_d) begin
				rd_done_q <= 1'b0;
				rd_idx_q  <= (state_d == sit_pkg::ST_DEL) ? slot_idx + IDX_W'(1) : '0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (rd_idx_q == rd_last) begin
					rd_done_q <= 1'b1;
				end
			end
			if (accept) begin
				hit_q <= (req.data.kind == sit_pkg::KIND_WRITE) && in_range;
				cnt_q <= '0;
			end else if (rv_s1 && ((state_q == sit_pkg::ST_SCAN) ||
				(state_q == sit_pkg::ST_INS))) begin
				if (gt_key) begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
				if ((state_q == sit_pkg::ST_SCAN) && (rdata_eff == key_q) && (key_q != '0)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= rd_idx_q;
		vb_s1 <= valid_q[rd_idx_q];
		if (accept) begin
			key_q   <= (req.data.kind == sit_pkg::KIND_CLEAR) ? '0 : req.data.user_id;
			carry_q <= (req.data.kind == sit_pkg::KIND_CLEAR) ? '0 : req.data.user_id;
		end else if ((state_q == sit_pkg::ST_INS) && rv_s1 && !gt_carry) begin
			carry_q <= rdata_eff;
		end
	end

endmodule

/* hdl/sit_out.sv */
// result output register
`timescale 1ns / 1ps

module sit_out (
	input  logic          clk,
	input  logic          arst_n,
	input  sit_pkg::res_t res,
	output logic          out_free,
	sit_stream_if.source  rsp
);

	logic          full_q;
	sit_pkg::rsp_t data_q;

	assign out_free  = !full_q || rsp.ready;
	assign rsp.valid = full_q;
	assign rsp.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (res.valid) begin
			full_q <= 1'b1;
		end else if (rsp.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			data_q <= res.data;
		end
	end

endmodule

/* hdl/sorted_id_table_unit.sv */
// top level of the sorted id table: sequencer, id ram and output register
//
// channel  dir  beat
// req      in   kind, slot, user_id
// rsp      out  hit, position
//
// one item at a time; the id ram moves one read and one write per cycle
// lookup: one scan pass of N reads from accept to result
// write or clear: delete pass, insert pass, tail write; the last slot skips the delete pass
// unused kind or slot out of range: straight to the result
// reset empties the table at once through per-entry valid bits
// a held result stalls only the finish of the following item
`timescale 1ns / 1ps

module sorted_id_table_unit #(
	parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sit_stream_if.sink   req,
	sit_stream_if.source rsp
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	sit_pkg::res_t           res;
	logic                    out_free;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [sit_pkg::ID_W-1:0] ram_wdata;
	logic [IDX_W-1:0]        ram_raddr;
	logic [sit_pkg::ID_W-1:0] ram_rdata;

	sit_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	sit_ram #(
		.WIDTH(sit_pkg::ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sit_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.out_free(out_free),
		.rsp     (rsp)
	);

endmodule

/* hdl/sit_chk.sv */
// port-level assertions for the sorted id table, bound to the top level
`timescale 1ns / 1ps

module sit_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_hit,
	input logic [sit_pkg::POS_W-1:0] rsp_position
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous item still in work");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_hit || (rsp_position == '0)))
		else $error("nonzero position on a miss");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("new result without returning to idle");

endmodule

bind sorted_id_table_unit sit_chk u_sit_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_hit     (rsp.data.hit),
	.rsp_position(rsp.data.position)
);
